/* sv/tcp_pkg.sv */
// ---------------------------------------------------------------------------
// TLS ClientHello parser package
// Shared types, codes and the cipher suite table.
// ---------------------------------------------------------------------------
package tcp_pkg;

    localparam int MaxMessage = 4096;
    localparam int NumCiphers = 16;
    localparam int TableSize  = 16;

    localparam logic [3:0] PH_HDR     = 4'd0;
    localparam logic [3:0] PH_TYPE    = 4'd1;
    localparam logic [3:0] PH_FIXED   = 4'd2;
    localparam logic [3:0] PH_SIDLEN  = 4'd3;
    localparam logic [3:0] PH_SID     = 4'd4;
    localparam logic [3:0] PH_CIPHERS = 4'd5;
    localparam logic [3:0] PH_COMPLEN = 4'd6;
    localparam logic [3:0] PH_COMP    = 4'd7;
    localparam logic [3:0] PH_EXTHDR  = 4'd8;
    localparam logic [3:0] PH_EXTSKIP = 4'd9;
    localparam logic [3:0] PH_SNI     = 4'd10;
    localparam logic [3:0] PH_ALPN    = 4'd11;
    localparam logic [3:0] PH_IDLE    = 4'd12;
    localparam logic [3:0] PH_OWED    = 4'd13;

    localparam logic [2:0] K_CIPHER = 3'd0;
    localparam logic [2:0] K_SNI    = 3'd1;
    localparam logic [2:0] K_SNIEND = 3'd2;
    localparam logic [2:0] K_DONE   = 3'd3;
    localparam logic [2:0] K_ERROR  = 3'd4;
    localparam logic [2:0] K_NOTCH  = 3'd5;

    localparam logic [7:0] E_BUF_SHORT = 8'd1;
    localparam logic [7:0] E_TOO_LONG  = 8'd2;
    localparam logic [7:0] E_OVERRUN   = 8'd3;
    localparam logic [7:0] E_ODD_CIPH  = 8'd4;
    localparam logic [7:0] E_SNI_LONG  = 8'd5;
    localparam logic [7:0] E_SNI_RUN   = 8'd6;
    localparam logic [7:0] E_ALPN_LONG = 8'd7;
    localparam logic [7:0] E_ALPN_RUN  = 8'd8;
    localparam logic [7:0] E_ALPN_NONE = 8'd9;

    localparam logic [15:0] EXT_SNI  = 16'h0000;
    localparam logic [15:0] EXT_ALPN = 16'h0010;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } tcp_in_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       final_res;
    } tcp_out_t;

    function automatic logic [15:0] suite_code(input logic [3:0] idx);
        logic [15:0] c;
        begin
            case (idx)
                4'd0:    c = 16'h1301;
                4'd1:    c = 16'h1302;
                4'd2:    c = 16'h1303;
                4'd3:    c = 16'hc02b;
                4'd4:    c = 16'hc02f;
                4'd5:    c = 16'hc02c;
                4'd6:    c = 16'hc030;
                4'd7:    c = 16'hcca9;
                4'd8:    c = 16'hcca8;
                4'd9:    c = 16'hc013;
                4'd10:   c = 16'hc014;
                4'd11:   c = 16'h009c;
                4'd12:   c = 16'h009d;
                4'd13:   c = 16'h002f;
                4'd14:   c = 16'h0035;
                default: c = 16'h000a;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] h2_char(input logic idx);
        return idx ? 8'h32 : 8'h68;
    endfunction

    function automatic logic [7:0] h11_char(input logic [2:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                3'd0:    c = 8'h68;
                3'd1:    c = 8'h74;
                3'd2:    c = 8'h74;
                3'd3:    c = 8'h70;
                3'd4:    c = 8'h2f;
                3'd5:    c = 8'h31;
                3'd6:    c = 8'h2e;
                default: c = 8'h31;
            endcase
            return c;
        end
    endfunction

endpackage

/* sv/tls_client_hello_parser_top.sv */
// ---------------------------------------------------------------------------
// TLS ClientHello parser
// Byte-stream parser reporting cipher matches, SNI host name and ALPN flags.
// ---------------------------------------------------------------------------
// The parser takes one record byte per request on the input channel and gives
// at most one result per byte. A byte is taken every cycle as long as the
// input register is empty or the output register is free or being drained:
// every byte passes through one input register, the parse logic and one
// result register, so the rate is one byte per clock unless the output stalls.
// A byte's result is loaded into the result register when the parse stage
// advances, and out_valid comes straight from that register. Results:
// cipher matches carry the suite table index, host name bytes stream as SNI
// requests closed by an SNI-end request, and the record closes with done
// (ALPN flags h2 in bit 0, http/1.1 in bit 1) or a numbered error, both with
// final_res set. After a final result bytes are dropped up to and including
// the next one marked last_byte.
// ---------------------------------------------------------------------------
module tls_client_hello_parser_top
    import tcp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tcp_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output tcp_out_t out_data
);

    // input register
    logic    iv_reg;
    tcp_in_t id_reg;
    // output register
    logic     ov_reg;
    tcp_out_t od_reg;

    logic [3:0]  ph_reg, ph_next;
    logic [15:0] off_reg, off_next;
    logic [15:0] rend_reg, rend_next;
    logic [15:0] send_reg, send_next;
    logic [15:0] skip_reg, skip_next;
    logic [7:0]  hb_reg, hb_next;
    logic [15:0] ext_reg, ext_next;
    logic [7:0]  elen_reg, elen_next;
    logic [7:0]  epos_reg, epos_next;
    logic [1:0]  cand_reg, cand_next;
    logic [1:0]  prot_reg, prot_next;
    logic [1:0]  seen_reg, seen_next;

    logic        have, fin, owe;
    logic [2:0]  rkind;
    logic [7:0]  rval;

    logic        advance;
    // parse stage may move when output register is free or drains
    assign advance  = !ov_reg || out_ready;
    assign in_ready = !iv_reg || advance;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        logic [7:0]  b;
        logic        ends;
        logic [16:0] e;
        logic [16:0] len;
        logic [15:0] code;
        logic [15:0] skd;
        logic [1:0]  cm;
        logic [1:0]  pf;
        logic        alpn_cl;
        logic        sni_cl;
        logic        stop;
        b = id_reg.data_byte;
        ph_next = ph_reg; off_next = off_reg; rend_next = rend_reg;
        send_next = send_reg; skip_next = skip_reg; hb_next = hb_reg;
        ext_next = ext_reg; elen_next = elen_reg; epos_next = epos_reg;
        cand_next = cand_reg; prot_next = prot_reg; seen_next = seen_reg;
        have = 1'b0; fin = 1'b0; owe = 1'b0; rkind = K_CIPHER; rval = 8'd0;
        ends = (off_reg + 16'd1) == send_reg;
        e = 17'd0; len = 17'd0; code = 16'd0; skd = skip_reg - 16'd1;
        cm = 2'd0; pf = prot_reg; alpn_cl = 1'b0; sni_cl = 1'b0; stop = 1'b0;

        if (ph_reg == PH_IDLE) begin
            if (id_reg.last_byte) begin
                ph_next = PH_HDR; off_next = 16'd0;
            end
        end else if (ph_reg == PH_OWED) begin
            have = 1'b1; fin = 1'b1; rkind = K_DONE; rval = {6'd0, prot_reg};
        end else begin
            case (ph_reg)
                PH_HDR: begin
                    if (off_reg == 16'd0) begin
                        rend_next = '0; send_next = '0; skip_next = '0;
                        hb_next = '0; ext_next = '0; elen_next = '0;
                        epos_next = '0; cand_next = '0; prot_next = '0;
                        seen_next = '0;
                    end
                    if (off_reg == 16'd3) hb_next = b;
                    if (off_reg >= 16'd4) begin
                        e = {1'b0, hb_reg, b} + 17'd5;
                        if (e > 17'(MaxMessage)) begin
                            have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_TOO_LONG;
                        end else begin
                            rend_next = e[15:0]; ph_next = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    if (b != 8'h01) begin
                        have = 1'b1; fin = 1'b1; rkind = K_NOTCH; rval = 8'd0;
                    end else ph_next = PH_FIXED;
                end
                PH_FIXED: begin
                    if (off_reg >= 16'd42) ph_next = PH_SIDLEN;
                end
                PH_SIDLEN: begin
                    skip_next = {8'd0, b}; epos_next = 8'd0;
                    ph_next = (b != 8'd0) ? PH_SID : PH_CIPHERS;
                end
                PH_SID: begin
                    skip_next = skd;
                    if (skd == 16'd0) begin
                        ph_next = PH_CIPHERS; epos_next = 8'd0;
                    end
                end
                PH_CIPHERS: begin
                    if (epos_reg == 8'd0 || epos_reg == 8'd2) begin
                        hb_next = b; epos_next = epos_reg + 8'd1;
                    end else if (epos_reg == 8'd1) begin
                        len = {1'b0, hb_reg, b};
                        e = {1'b0, off_reg} + 17'd1 + len;
                        if (b[0]) begin
                            have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_ODD_CIPH;
                        end else if (e > {1'b0, rend_reg}) begin
                            have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_OVERRUN;
                        end else begin
                            send_next = e[15:0];
                            if (len == 17'd0) ph_next = PH_COMPLEN;
                            else epos_next = 8'd2;
                        end
                    end else begin
                        code = {hb_reg, b};
                        for (int i = TableSize - 1; i >= 0; i--) begin
                            if (i < NumCiphers && suite_code(4'(i)) == code) begin
                                have = 1'b1; rkind = K_CIPHER; rval = 8'(i);
                            end
                        end
                        if (ends) ph_next = PH_COMPLEN;
                        else epos_next = 8'd2;
                    end
                end
                PH_COMPLEN: begin
                    skip_next = {8'd0, b} + 16'd2; ph_next = PH_COMP;
                end
                PH_COMP: begin
                    skip_next = skd;
                    if (skd == 16'd0) begin
                        ph_next = PH_EXTHDR; epos_next = 8'd0;
                    end
                end
                PH_EXTHDR: begin
                    if (epos_reg == 8'd0) begin
                        ext_next = {b, 8'd0}; epos_next = 8'd1;
                    end else if (epos_reg == 8'd1) begin
                        ext_next = {ext_reg[15:8], b}; epos_next = 8'd2;
                    end else if (epos_reg == 8'd2) begin
                        hb_next = b; epos_next = 8'd3;
                    end else begin
                        len = {1'b0, hb_reg, b};
                        e = {1'b0, off_reg} + 17'd1 + len;
                        if (e > {1'b0, rend_reg}) begin
                            have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_OVERRUN;
                        end else begin
                            send_next = e[15:0]; epos_next = 8'd0;
                            if (ext_reg == EXT_SNI && !seen_reg[0]) begin
                                if (hb_reg != 8'd0) begin
                                    have = 1'b1; fin = 1'b1; rkind = K_ERROR;
                                    rval = E_SNI_LONG;
                                end else if (len == 17'd0) begin
                                    have = 1'b1; fin = 1'b1; rkind = K_ERROR;
                                    rval = E_SNI_RUN;
                                end else ph_next = PH_SNI;
                            end else if (ext_reg == EXT_ALPN && !seen_reg[1]) begin
                                if (len == 17'd0) begin
                                    have = 1'b1; fin = 1'b1; rkind = K_ERROR;
                                    rval = E_ALPN_RUN;
                                end else begin
                                    ph_next = PH_ALPN; skip_next = 16'd0;
                                end
                            end else if (len != 17'd0) ph_next = PH_EXTSKIP;
                        end
                    end
                end
                PH_EXTSKIP: begin
                    if (ends) begin
                        ph_next = PH_EXTHDR; epos_next = 8'd0;
                    end
                end
                PH_SNI: begin
                    if (epos_reg >= 8'd5) begin
                        skip_next = skd;
                        have = 1'b1; rval = b;
                        if (skd == 16'd0) begin
                            rkind = K_SNIEND; sni_cl = 1'b1;
                        end else rkind = K_SNI;
                    end else if (epos_reg == 8'd3 && b != 8'd0) begin
                        have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_SNI_LONG;
                    end else if (epos_reg == 8'd4) begin
                        elen_next = b;
                        e = {1'b0, off_reg} + 17'd1 + {9'd0, b};
                        if (e > {1'b0, send_reg}) begin
                            have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_SNI_RUN;
                        end else if (b == 8'd0) begin
                            have = 1'b1; rkind = K_SNIEND; rval = 8'd0; sni_cl = 1'b1;
                        end else begin
                            skip_next = {8'd0, b}; epos_next = 8'd5;
                        end
                    end else if (ends) begin
                        have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_SNI_RUN;
                    end else epos_next = epos_reg + 8'd1;
                    if (sni_cl) begin
                        seen_next = seen_reg | 2'b01;
                        ph_next = ends ? PH_EXTHDR : PH_EXTSKIP;
                        epos_next = 8'd0;
                        // done owed: sni end already occupies this byte
                        if (seen_reg[1]) owe = 1'b1;
                    end
                end
                PH_ALPN: begin
                    if (epos_reg == 8'd0) begin
                        if (b != 8'd0) begin
                            have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_ALPN_LONG;
                        end else if (ends) begin
                            have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_ALPN_RUN;
                        end else epos_next = 8'd1;
                    end else if (epos_reg == 8'd1) begin
                        e = {1'b0, off_reg} + 17'd1 + {9'd0, b};
                        if (e > {1'b0, send_reg}) begin
                            have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_ALPN_RUN;
                        end else if (b == 8'd0) alpn_cl = 1'b1;
                        else begin
                            skip_next = {8'd0, b}; elen_next = 8'd0; epos_next = 8'd2;
                        end
                    end else begin
                        skip_next = skd;
                        if (elen_reg == 8'd0) begin
                            if ({8'd0, b} > skd) begin
                                have = 1'b1; fin = 1'b1; rkind = K_ERROR;
                                rval = E_ALPN_RUN;
                            end else begin
                                elen_next = b; hb_next = 8'd0;
                                cand_next = {b == 8'd8, b == 8'd2};
                                if (skd == 16'd0) alpn_cl = 1'b1;
                            end
                        end else begin
                            cm = cand_reg;
                            if (cm[0] && (hb_reg >= 8'd2 || b != h2_char(hb_reg[0])))
                                cm[0] = 1'b0;
                            if (cm[1] && (hb_reg >= 8'd8 || b != h11_char(hb_reg[2:0])))
                                cm[1] = 1'b0;
                            cand_next = cm;
                            hb_next = hb_reg + 8'd1;
                            elen_next = elen_reg - 8'd1;
                            if (elen_reg == 8'd1) pf = prot_reg | cm;
                            prot_next = pf;
                            if (skd == 16'd0) alpn_cl = 1'b1;
                        end
                    end
                    if (alpn_cl) begin
                        if (pf == 2'd0) begin
                            have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_ALPN_NONE;
                        end else begin
                            seen_next = seen_reg | 2'b10;
                            ph_next = ends ? PH_EXTHDR : PH_EXTSKIP;
                            epos_next = 8'd0;
                            if (seen_reg[0]) begin
                                have = 1'b1; fin = 1'b1; rkind = K_DONE;
                                rval = {6'd0, pf};
                            end
                        end
                    end
                end
                default: begin
                    ph_next = PH_HDR;
                end
            endcase
            if (ph_reg > PH_OWED) begin
                off_next = '0; rend_next = '0; send_next = '0; skip_next = '0;
                hb_next = '0; ext_next = '0; elen_next = '0; epos_next = '0;
                cand_next = '0; prot_next = '0; seen_next = '0;
            end else begin
                if (!fin && !owe && rend_next != 16'd0 &&
                    (off_reg + 16'd1) == rend_next) begin
                    stop = (ph_next == PH_EXTHDR && epos_next == 8'd0) ||
                           (ph_next == PH_COMP && skip_next == 16'd2);
                    if (stop) begin
                        if (have) owe = 1'b1;
                        else begin
                            have = 1'b1; fin = 1'b1; rkind = K_DONE;
                            rval = {6'd0, prot_next};
                        end
                    end else begin
                        have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_OVERRUN;
                    end
                end
                off_next = off_reg + 16'd1;
            end
        end

        if (ph_reg != PH_IDLE && ph_reg <= PH_OWED) begin
            if (fin) begin
                ph_next = id_reg.last_byte ? PH_HDR : PH_IDLE;
                off_next = 16'd0;
            end else if (owe) begin
                ph_next = PH_OWED;
            end else if (id_reg.last_byte) begin
                have = 1'b1; fin = 1'b1; rkind = K_ERROR; rval = E_BUF_SHORT;
                ph_next = PH_HDR; off_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            iv_reg <= 1'b0;
            ov_reg <= 1'b0;
            ph_reg <= PH_HDR;
            off_reg <= '0; rend_reg <= '0; send_reg <= '0; skip_reg <= '0;
            hb_reg <= '0; ext_reg <= '0; elen_reg <= '0; epos_reg <= '0;
            cand_reg <= '0; prot_reg <= '0; seen_reg <= '0;
        end else begin
            if (in_ready) begin
                iv_reg <= in_valid;
                id_reg <= in_data;
            end
            if (advance) begin
                ov_reg <= iv_reg && have;
                if (iv_reg) begin
                    od_reg <= '{kind: rkind, value: rval, final_res: fin};
                    ph_reg <= ph_next; off_reg <= off_next; rend_reg <= rend_next;
                    send_reg <= send_next; skip_reg <= skip_next; hb_reg <= hb_next;
                    ext_reg <= ext_next; elen_reg <= elen_next;
                    epos_reg <= epos_next; cand_reg <= cand_next;
                    prot_reg <= prot_next; seen_reg <= seen_next;
                end
            end
        end
    end

    // result register holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> ov_reg && $stable(od_reg))
        else $error("result changed while stalled");
    // entering the owed-done phase always comes with an sni end result
    a_owed: assert property (@(posedge clk) disable iff (!rst_n)
        (ph_reg != PH_OWED) ##1 (ph_reg == PH_OWED) |-> ov_reg && od_reg.kind == K_SNIEND)
        else $error("owed done without sni end");
    // final results carry only final kinds
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && od_reg.final_res |-> od_reg.kind == K_DONE ||
        od_reg.kind == K_ERROR || od_reg.kind == K_NOTCH)
        else $error("final flag on wrong kind");

endmodule
